>>> rtl/pcve_pkg.sv
package pcve_pkg;

  localparam int WordW   = 32;
  localparam int CoordW  = 16;
  localparam int NumVert = 4;
  localparam int CountW  = 3;
  localparam int NvpW    = 4;

  localparam logic [7:0] OP_CLASS_MASK = 8'hE0;
  localparam logic [7:0] OP_CLASS_POLY = 8'h20;
  localparam logic [7:0] OP_TEXTURED   = 8'h04;
  localparam logic [7:0] OP_QUAD       = 8'h08;
  localparam logic [7:0] OP_GOURAUD    = 8'h10;

  localparam logic [CountW-1:0] TRI_VERTS  = 3'd3;
  localparam logic [CountW-1:0] QUAD_VERTS = 3'd4;
  localparam logic [NvpW-1:0]   FIRST_VERT_POS = 4'd2;

  typedef struct packed {
    logic                             known;
    logic                             quad;
    logic [CountW-1:0]                count;
    logic [NumVert-1:0][CoordW-1:0]   vx;
    logic [NumVert-1:0][CoordW-1:0]   vy;
  } pcve_result_t;

endpackage

>>> rtl/pcve_if.sv
interface pcve_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic        word_last;

  modport source (output valid, output packet_word, output word_last, input ready);
  modport sink (input valid, input packet_word, input word_last, output ready);
endinterface

interface pcve_result_if;
  logic               valid;
  logic               ready;
  logic               geometry_known;
  logic               is_quad;
  logic [2:0]         vertex_count;
  logic signed [15:0] vert0_x;
  logic signed [15:0] vert0_y;
  logic signed [15:0] vert1_x;
  logic signed [15:0] vert1_y;
  logic signed [15:0] vert2_x;
  logic signed [15:0] vert2_y;
  logic signed [15:0] vert3_x;
  logic signed [15:0] vert3_y;

  modport source (
    output valid, output geometry_known, output is_quad, output vertex_count,
    output vert0_x, output vert0_y, output vert1_x, output vert1_y,
    output vert2_x, output vert2_y, output vert3_x, output vert3_y,
    input ready
  );
  modport sink (
    input valid, input geometry_known, input is_quad, input vertex_count,
    input vert0_x, input vert0_y, input vert1_x, input vert1_y,
    input vert2_x, input vert2_y, input vert3_x, input vert3_y,
    output ready
  );
endinterface

>>> rtl/pcve_parse.sv
module pcve_parse
  import pcve_pkg::*;
#(
  parameter int MAX_WORDS = 13
) (
  input  logic          clk,
  input  logic          rst,
  pcve_word_if.sink     words,
  output pcve_result_t  res,
  output logic          res_valid,
  input  logic          res_ready
);

  localparam int PosW = $clog2(MAX_WORDS + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_WORDS);

  // input register
  logic              in_valid;
  logic [WordW-1:0]  in_word;
  logic              in_last;
  logic              consume;

  // packet state
  logic [PosW-1:0]   word_position;
  logic              command_is_polygon;
  logic              flag_textured;
  logic              flag_quad;
  logic              flag_gouraud;
  logic [CountW-1:0] vertices_found;
  logic [NvpW-1:0]   next_vertex_position;
  logic [NumVert-1:0][WordW-1:0] vertex_coords;

  logic              active;
  logic              header;
  logic              capture;
  logic [CountW-1:0] needed;
  logic [CountW-1:0] found_next;
  logic [NvpW-1:0]   nvp_next;
  logic [7:0]        op;
  logic              known;
  logic [NumVert-1:0][WordW-1:0] vtx;

  assign consume     = in_valid && (!in_last || res_ready);
  assign words.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (words.ready) begin
      in_valid <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      in_word <= words.packet_word;
      in_last <= words.word_last;
    end
  end

  always_comb begin
    op      = in_word[31:24];
    active  = word_position < MaxPos;
    header  = active && (word_position == PosW'(1));
    needed  = flag_quad ? QUAD_VERTS : TRI_VERTS;
    capture = active && (word_position >= PosW'(2)) && command_is_polygon &&
              (vertices_found < needed) &&
              (word_position == PosW'(next_vertex_position));
    nvp_next = next_vertex_position + NvpW'(1) + NvpW'(flag_textured) +
               NvpW'(flag_gouraud && ((vertices_found + CountW'(1)) < needed));
    found_next = capture ? vertices_found + CountW'(1) : vertices_found;
    for (int k = 0; k < NumVert; k++) begin
      vtx[k] = (capture && (vertices_found[1:0] == 2'(k))) ? in_word : vertex_coords[k];
    end
    known = command_is_polygon && (found_next == needed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position        <= '0;
      command_is_polygon   <= 1'b0;
      flag_textured        <= 1'b0;
      flag_quad            <= 1'b0;
      flag_gouraud         <= 1'b0;
      vertices_found       <= '0;
      next_vertex_position <= FIRST_VERT_POS;
    end else if (consume) begin
      if (in_last) begin
        // start over for the next packet
        word_position        <= '0;
        command_is_polygon   <= 1'b0;
        flag_textured        <= 1'b0;
        flag_quad            <= 1'b0;
        flag_gouraud         <= 1'b0;
        vertices_found       <= '0;
        next_vertex_position <= FIRST_VERT_POS;
      end else begin
        if (active) begin
          word_position <= word_position + PosW'(1);
        end
        if (header) begin
          command_is_polygon <= (op & OP_CLASS_MASK) == OP_CLASS_POLY;
          flag_textured      <= (op & OP_TEXTURED) != 8'h00;
          flag_quad          <= (op & OP_QUAD) != 8'h00;
          flag_gouraud       <= (op & OP_GOURAUD) != 8'h00;
        end
        if (capture) begin
          vertices_found       <= found_next;
          next_vertex_position <= nvp_next;
        end
      end
    end
  end

  // coordinates are only read back once every needed slot is written
  always_ff @(posedge clk) begin
    if (consume && capture) begin
      vertex_coords[vertices_found[1:0]] <= in_word;
    end
  end

  assign res_valid = in_valid && in_last;

  always_comb begin
    res = '0;
    if (known) begin
      res.known = 1'b1;
      res.quad  = flag_quad;
      res.count = needed;
      for (int k = 0; k < NumVert; k++) begin
        res.vx[k] = vtx[k][CoordW-1:0];
        res.vy[k] = vtx[k][WordW-1:CoordW];
      end
      if (!flag_quad) begin
        res.vx[NumVert-1] = '0;
        res.vy[NumVert-1] = '0;
      end
    end
  end

endmodule

>>> rtl/pcve_out_reg.sv
module pcve_out_reg
  import pcve_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  pcve_result_t  res,
  input  logic          res_valid,
  output logic          res_ready,
  pcve_result_if.source result
);

  logic         out_valid;
  pcve_result_t out_data;

  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.geometry_known = out_data.known;
  assign result.is_quad        = out_data.quad;
  assign result.vertex_count   = out_data.count;
  assign result.vert0_x        = $signed(out_data.vx[0]);
  assign result.vert0_y        = $signed(out_data.vy[0]);
  assign result.vert1_x        = $signed(out_data.vx[1]);
  assign result.vert1_y        = $signed(out_data.vy[1]);
  assign result.vert2_x        = $signed(out_data.vx[2]);
  assign result.vert2_y        = $signed(out_data.vy[2]);
  assign result.vert3_x        = $signed(out_data.vx[3]);
  assign result.vert3_y        = $signed(out_data.vy[3]);

endmodule

>>> rtl/polygon_command_vertex_extract.sv
// A packet's result is formed from its last word in the word register and is then held in the result register.
// Throughput: one word per cycle; the word register and the result register
// keep words flowing while a finished result waits to be taken.
// A stalled result blocks only the following packet's last word.
// Reset (rst, synchronous) empties both registers and returns to a packet start.
module polygon_command_vertex_extract
  import pcve_pkg::*;
#(
  parameter int MAX_WORDS = 13
) (
  input  logic          clk,
  input  logic          rst,
  pcve_word_if.sink     words,
  pcve_result_if.source result
);

  pcve_result_t res;
  logic         res_valid;
  logic         res_ready;

  pcve_parse #(
    .MAX_WORDS(MAX_WORDS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .words     (words),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  pcve_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> result.valid)
    else $error("request handed to output register was lost");

  a_known_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.geometry_known |->
      (result.vertex_count == TRI_VERTS) || (result.vertex_count == QUAD_VERTS))
    else $error("known geometry with bad vertex count");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.geometry_known |->
      (result.vertex_count == 3'd0) && !result.is_quad && (result.vert0_x == 16'sd0))
    else $error("unknown geometry with nonzero fields");

  a_quad_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_quad |-> result.vertex_count == QUAD_VERTS)
    else $error("quad result without four vertices");
`endif

endmodule

>>> verif/vertex_extract_checker.sv
`timescale 1ns / 1ps

module vertex_extract_checker
  import pcve_pkg::*;
#(
  parameter int MAX_WORDS = 13
) (
  input  logic        clk,
  input  logic        rst,
  pcve_word_if        words,
  pcve_result_if      result,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned geometry_hits,
  output int unsigned quad_hits
);

  // Packet parse state, mirrored from the expected behavior.
  int unsigned      word_idx;
  logic             poly;
  logic             textured;
  logic             quad;
  logic             gouraud;
  int unsigned      verts_got;
  int unsigned      vert_pos;
  logic [WordW-1:0] coords [NumVert];

  pcve_result_t expected_geometry[$];

  function automatic void new_packet();
    word_idx  = 0;
    poly      = 1'b0;
    textured  = 1'b0;
    quad      = 1'b0;
    gouraud   = 1'b0;
    verts_got = 0;
    vert_pos  = int'(FIRST_VERT_POS);
    for (int k = 0; k < NumVert; k++) coords[k] = '0;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    failures++;
    if (failures <= 100)
      $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic absorb_word(input logic [WordW-1:0] w, input logic last);
    logic [7:0]   cmd;
    int unsigned  want;
    pcve_result_t r;
    if (word_idx < MAX_WORDS) begin
      if (word_idx == 1) begin
        cmd      = w[31:24];
        poly     = (cmd & OP_CLASS_MASK) == OP_CLASS_POLY;
        textured = (cmd & OP_TEXTURED) != 0;
        quad     = (cmd & OP_QUAD) != 0;
        gouraud  = (cmd & OP_GOURAUD) != 0;
      end else if (word_idx >= 2 && poly) begin
        want = quad ? int'(QUAD_VERTS) : int'(TRI_VERTS);
        if (verts_got < want && word_idx == vert_pos) begin
          coords[verts_got] = w;
          // skip the texture word and, between vertices, the color word
          vert_pos += 1 + (textured ? 1 : 0) + ((gouraud && verts_got + 1 < want) ? 1 : 0);
          verts_got++;
        end
      end
      word_idx++;
    end
    if (last) begin
      want = quad ? int'(QUAD_VERTS) : int'(TRI_VERTS);
      r = '0;
      if (poly && word_idx >= 2 && verts_got == want) begin
        r.known = 1'b1;
        r.quad  = quad;
        r.count = quad ? QUAD_VERTS : TRI_VERTS;
        for (int k = 0; k < NumVert; k++) begin
          r.vx[k] = coords[k][15:0];
          r.vy[k] = coords[k][31:16];
        end
        geometry_hits++;
        if (quad) quad_hits++;
      end
      expected_geometry.insert(expected_geometry.size(), r);
      new_packet();
    end
  endtask

  task automatic check_result(input pcve_result_t want);
    logic [CoordW-1:0] got_x [NumVert];
    logic [CoordW-1:0] got_y [NumVert];
    got_x[0] = result.vert0_x;
    got_y[0] = result.vert0_y;
    got_x[1] = result.vert1_x;
    got_y[1] = result.vert1_y;
    got_x[2] = result.vert2_x;
    got_y[2] = result.vert2_y;
    got_x[3] = result.vert3_x;
    got_y[3] = result.vert3_y;
    if (result.geometry_known !== want.known)
      report("geometry_known", 32'(result.geometry_known), 32'(want.known));
    if (result.is_quad !== want.quad)
      report("is_quad", 32'(result.is_quad), 32'(want.quad));
    if (result.vertex_count !== want.count)
      report("vertex_count", 32'(result.vertex_count), 32'(want.count));
    for (int k = 0; k < NumVert; k++) begin
      if (got_x[k] !== want.vx[k])
        report($sformatf("vert%0d_x", k), 32'(got_x[k]), 32'(want.vx[k]));
      if (got_y[k] !== want.vy[k])
        report($sformatf("vert%0d_y", k), 32'(got_y[k]), 32'(want.vy[k]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_geometry.delete();
      new_packet();
      pending = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_geometry.size() == 0)
          report("result with no packet outstanding", 32'(result.geometry_known), 32'd0);
        else
          check_result(expected_geometry.pop_front());
      end
      if (words.valid && words.ready)
        absorb_word(words.packet_word, words.word_last);
      pending = expected_geometry.size();
    end
  end

endmodule

>>> verif/tb_polygon_command_vertex_extract.sv
`timescale 1ns / 1ps

module tb_polygon_command_vertex_extract;
  import pcve_pkg::*;

  localparam int MaxWords   = 13;
  localparam int WordTarget = 1750;

  logic clk;
  logic rst;

  pcve_word_if   words();
  pcve_result_if result();

  int unsigned failures;
  int unsigned pending;
  int unsigned geometry_hits;
  int unsigned quad_hits;

  int unsigned      burst_left;
  int unsigned      counted_words;
  int unsigned      packets_sent;
  logic [WordW-1:0] pkt_words [0:31];
  int unsigned      pkt_len;

  polygon_command_vertex_extract #(
    .MAX_WORDS(MaxWords)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .words (words),
    .result(result)
  );

  vertex_extract_checker #(
    .MAX_WORDS(MaxWords)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .words        (words),
    .result       (result),
    .failures     (failures),
    .pending      (pending),
    .geometry_hits(geometry_hits),
    .quad_hits    (quad_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[polygon_command_vertex_extract] ERROR");
    $finish;
  end

  // Result side: switch between randomly chosen stall patterns.
  initial begin
    int unsigned stall_mode;
    int unsigned stall_left;
    stall_left = 0;
    stall_mode = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 1) == 1);
        2: result.ready <= ($urandom_range(0, 7) == 0);
        default: result.ready <= (stall_left % 5) < 3;
      endcase
    end
  end

  function automatic logic [15:0] coord_half();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Number of words a well-formed packet for this command carries.
  function automatic int unsigned packet_span(input logic [7:0] cmd);
    int unsigned n;
    n = ((cmd & OP_QUAD) != 0) ? 4 : 3;
    return 2 + n * (((cmd & OP_TEXTURED) != 0) ? 2 : 1)
           + (((cmd & OP_GOURAUD) != 0) ? n - 1 : 0);
  endfunction

  task automatic build_packet(input logic [7:0] cmd, input int unsigned len);
    pkt_words[0] = $urandom;
    pkt_words[1] = {cmd, 24'($urandom)};
    for (int i = 2; i < 32; i++) pkt_words[i] = {coord_half(), coord_half()};
    pkt_len = len;
  endtask

  task automatic put_word(input logic [WordW-1:0] w, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        words.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    words.valid       <= 1'b1;
    words.packet_word <= w;
    words.word_last   <= last;
    do @(posedge clk); while (!words.ready);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int unsigned i = 0; i < pkt_len; i++) begin
      put_word(pkt_words[i], i == pkt_len - 1);
      // words past the position limit are dropped by the block
      if (i < MaxWords) counted_words++;
    end
    packets_sent++;
  endtask

  // Hold the request side until every outstanding result has been taken.
  task automatic drain_results();
    words.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0]  cmd;
    int unsigned span;
    int unsigned len;
    int unsigned sel;

    burst_left    = 0;
    counted_words = 0;
    packets_sent  = 0;
    rst               = 1'b1;
    words.valid       = 1'b0;
    words.packet_word = '0;
    words.word_last   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Header-only packet.
    build_packet(OP_CLASS_POLY, 1);
    pkt_words[0] = 32'hFFFF_FFFF;
    send_packet();

    // Polygon command with no vertex words.
    build_packet(OP_CLASS_POLY | OP_QUAD, 2);
    pkt_words[0] = 32'h0000_0000;
    pkt_words[1] = {OP_CLASS_POLY | OP_QUAD, 24'h000000};
    send_packet();

    // Non-polygon command.
    build_packet(OP_CLASS_MASK, 3);
    pkt_words[1] = {OP_CLASS_MASK, 24'hFFFFFF};
    pkt_words[2] = 32'h0000_0000;
    send_packet();

    // Triangle cut short one vertex early.
    build_packet(OP_CLASS_POLY, 4);
    send_packet();

    // Textured gouraud quad running past the position limit.
    cmd = OP_CLASS_POLY | OP_TEXTURED | OP_QUAD | OP_GOURAUD;
    build_packet(cmd, 15);
    pkt_words[2]  = {16'h8000, 16'h7FFF};
    pkt_words[5]  = {16'h7FFF, 16'h8000};
    pkt_words[8]  = 32'hFFFF_FFFF;
    pkt_words[11] = 32'h0000_0000;
    send_packet();

    drain_results();

    while (counted_words < WordTarget) begin
      cmd  = 8'($urandom);
      cmd  = (cmd & ~OP_CLASS_MASK) | OP_CLASS_POLY;
      span = packet_span(cmd);
      sel  = $urandom_range(0, 99);
      if (sel < 62) begin
        len = span + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (sel < 74) begin
        len = $urandom_range(2, span - 1);
      end else if (sel < 86) begin
        cmd = 8'($urandom);
        // move a polygon class over to another class
        if ((cmd & OP_CLASS_MASK) == OP_CLASS_POLY) cmd[7] = 1'b1;
        len = $urandom_range(1, MaxWords + 2);
      end else if (sel < 93) begin
        len = $urandom_range(MaxWords + 1, 24);
      end else begin
        len = $urandom_range(1, 2);
      end
      build_packet(cmd, len);
      send_packet();
      if ($urandom_range(0, 59) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(negedge clk);

    $display("Sent %0d packets (%0d counted words), including short, long and non-polygon ones.",
             packets_sent, counted_words);
    $display("Full geometry came back for %0d packets, %0d of them quads.",
             geometry_hits, quad_hits);
    if (failures == 0)
      $display("[polygon_command_vertex_extract] OK");
    else
      $display("[polygon_command_vertex_extract] ERROR");
    $finish;
  end

endmodule
